>>> hdl/jhpm_pkg.sv
// ----------------------------------------------------------------------------
// jhpm_pkg
// Shared types and constants of the joint histogram piecewise median block.
// ----------------------------------------------------------------------------
package jhpm_pkg;

  localparam int unsigned SOURCE_BINS_DEF = 256;
  localparam int unsigned TARGET_BINS_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF  = 24;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned BIN_W      = 9;
  localparam int unsigned LAST_W     = 8;
  localparam int unsigned ROW_W      = 9;
  localparam int unsigned TOTAL_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_MIN  = 2'd0,
    CFG_TARGET_MIN  = 2'd1,
    CFG_SOURCE_LAST = 2'd2,
    CFG_TARGET_LAST = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SMP_RD,
    ST_SMP_WR,
    ST_WALK,
    ST_TAIL,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] source_value;
    logic signed [VALUE_W-1:0] target_value;
    logic [BIN_W-1:0]          low_bin;
    logic [BIN_W-1:0]          high_bin;
  } in_item_t;

  typedef struct packed {
    logic signed [ROW_W-1:0] median_row;
    logic [TOTAL_W-1:0]      piece_total;
  } out_item_t;

endpackage

>>> hdl/jhpm_count_ram.sv
// ----------------------------------------------------------------------------
// jhpm_count_ram
// Pair count store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module jhpm_count_ram #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/joint_histogram_piecewise_median_core.sv
// ----------------------------------------------------------------------------
// joint_histogram_piecewise_median_core
// 2D joint histogram of (source, target) pairs with conditional median query.
// ----------------------------------------------------------------------------
// All counts live in one single-port-read, single-port-write memory of
// SOURCE_BINS*TARGET_BINS words, so every item is paced by that memory.
// After reset and after every clear item the block sweeps the whole memory,
// one word a cycle, during which in_stall is high. A sample item inside the
// spans passes through a read of its count, then a write of the incremented
// count; the next item is taken in the write cycle. A sample outside the
// spans and an unused op touch no memory and return straight to idle. A query
// walks the cells of its column range for all rows in use twice, one cell a
// cycle, first for the range total and then for the running sum; an empty
// range skips the walk. The result sits in an output register, so input items
// keep flowing while it waits to be taken; a second query holds at its end
// until the first result has left. Configuration writes are always ready.
module joint_histogram_piecewise_median_core #(
  parameter int unsigned SOURCE_BINS = jhpm_pkg::SOURCE_BINS_DEF,
  parameter int unsigned TARGET_BINS = jhpm_pkg::TARGET_BINS_DEF,
  parameter int unsigned COUNT_BITS  = jhpm_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  jhpm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output jhpm_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [jhpm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jhpm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned DEPTH     = SOURCE_BINS * TARGET_BINS;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam int unsigned SRC_CAP_I = (SOURCE_BINS > 256) ? 255 : SOURCE_BINS - 1;
  localparam int unsigned TGT_CAP_I = (TARGET_BINS > 256) ? 255 : TARGET_BINS - 1;
  localparam int unsigned SUM_RAW   = COUNT_BITS + $clog2(SRC_CAP_I + 1)
                                      + $clog2(TGT_CAP_I + 1);
  localparam int unsigned SUM_W     = (SUM_RAW > jhpm_pkg::TOTAL_W) ? SUM_RAW
                                                                   : jhpm_pkg::TOTAL_W;
  localparam int unsigned LW        = jhpm_pkg::LAST_W;
  localparam int unsigned BW        = jhpm_pkg::BIN_W;
  localparam int unsigned VW        = jhpm_pkg::VALUE_W;

  localparam logic [LW-1:0]         SRC_CAP    = LW'(SRC_CAP_I);
  localparam logic [LW-1:0]         TGT_CAP    = LW'(TGT_CAP_I);
  localparam logic [AW-1:0]         ROW_STRIDE = AW'(SOURCE_BINS);
  localparam logic [AW-1:0]         LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX    = '1;

  jhpm_pkg::state_t state_r, state_nxt;

  // configuration
  logic signed [VW-1:0] source_min_r, target_min_r;
  logic [LW-1:0]        source_last_r, target_last_r;
  logic [LW-1:0]        last_col, last_row;

  // item decode
  logic                 in_acc;
  logic signed [VW:0]   col_diff, row_diff;
  logic                 smp_in_span;
  logic [BW-1:0]        col_end, hi_clip;
  logic                 qry_empty;

  // sample path
  logic [LW-1:0]        smp_col_r, smp_row_r;
  logic [AW-1:0]        smp_addr_r, smp_cell_addr;

  // query walk
  logic [BW-1:0]        lo_r, hi_m1_r, col_r;
  logic [LW-1:0]        lr_r, row_r, prow_r;
  logic [AW-1:0]        base_r;
  logic                 pass_r, pv_r;
  logic                 walk_row_end, walk_last;
  logic [SUM_W-1:0]     acc_r, acc_sum, total_r, half_r;
  logic                 found_r;
  logic signed [jhpm_pkg::ROW_W-1:0] median_r;

  // clearing sweep
  logic [AW-1:0]        clr_addr_r;
  logic                 clr_last;

  // memory ports
  logic                  ram_wr_en, ram_rd_en;
  logic [AW-1:0]         ram_wr_addr, ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_wr_data, ram_rd_data;

  // result register
  logic                 out_valid_r, out_free, out_load;
  jhpm_pkg::out_item_t  out_data_r;

  jhpm_count_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (AW),
    .DATA_W (COUNT_BITS)
  ) u_count_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_min_r  <= '0;
      target_min_r  <= '0;
      source_last_r <= '1;
      target_last_r <= '1;
    end else if (cfg_valid) begin
      case (jhpm_pkg::cfg_idx_t'(cfg_index))
        jhpm_pkg::CFG_SOURCE_MIN:  source_min_r  <= cfg_data;
        jhpm_pkg::CFG_TARGET_MIN:  target_min_r  <= cfg_data;
        jhpm_pkg::CFG_SOURCE_LAST: source_last_r <= cfg_data[LW-1:0];
        jhpm_pkg::CFG_TARGET_LAST: target_last_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign last_col = (source_last_r > SRC_CAP) ? SRC_CAP : source_last_r;
  assign last_row = (target_last_r > TGT_CAP) ? TGT_CAP : target_last_r;

  // ---------------------------------------------------------------- decode
  assign in_acc   = in_valid && !in_stall;
  assign col_diff = (VW+1)'(in_data.source_value) - (VW+1)'(source_min_r);
  assign row_diff = (VW+1)'(in_data.target_value) - (VW+1)'(target_min_r);

  assign smp_in_span = !col_diff[VW] && !row_diff[VW]
                       && (col_diff[VW-1:0] <= VW'(last_col))
                       && (row_diff[VW-1:0] <= VW'(last_row));

  assign col_end   = BW'(last_col) + BW'(1);
  assign hi_clip   = (in_data.high_bin > col_end) ? col_end : in_data.high_bin;
  assign qry_empty = in_data.low_bin >= hi_clip;

  assign smp_cell_addr = AW'(smp_row_r) * ROW_STRIDE + AW'(smp_col_r);

  assign walk_row_end = col_r == hi_m1_r;
  assign walk_last    = walk_row_end && (row_r == lr_r);
  assign clr_last     = clr_addr_r == LAST_ADDR;

  assign acc_sum  = pv_r ? acc_r + SUM_W'(ram_rd_data) : acc_r;
  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jhpm_pkg::ST_CLEAR: begin
        if (clr_last) state_nxt = jhpm_pkg::ST_IDLE;
      end
      jhpm_pkg::ST_IDLE, jhpm_pkg::ST_SMP_WR: begin
        state_nxt = jhpm_pkg::ST_IDLE;
        if (in_acc) begin
          case (in_data.op)
            jhpm_pkg::OP_CLEAR:  state_nxt = jhpm_pkg::ST_CLEAR;
            jhpm_pkg::OP_SAMPLE: state_nxt = smp_in_span ? jhpm_pkg::ST_SMP_RD
                                                         : jhpm_pkg::ST_IDLE;
            jhpm_pkg::OP_QUERY:  state_nxt = qry_empty ? jhpm_pkg::ST_DONE
                                                       : jhpm_pkg::ST_WALK;
            default:             state_nxt = jhpm_pkg::ST_IDLE;
          endcase
        end
      end
      jhpm_pkg::ST_SMP_RD: state_nxt = jhpm_pkg::ST_SMP_WR;
      jhpm_pkg::ST_WALK: begin
        if (walk_last) state_nxt = jhpm_pkg::ST_TAIL;
      end
      jhpm_pkg::ST_TAIL: state_nxt = pass_r ? jhpm_pkg::ST_DONE : jhpm_pkg::ST_WALK;
      jhpm_pkg::ST_DONE: begin
        if (out_free) state_nxt = jhpm_pkg::ST_IDLE;
      end
      default: state_nxt = jhpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jhpm_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    in_stall    = 1'b1;
    ram_wr_en   = 1'b0;
    ram_wr_addr = clr_addr_r;
    ram_wr_data = '0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = base_r + AW'(col_r);
    out_load    = 1'b0;
    case (state_r)
      jhpm_pkg::ST_CLEAR: begin
        ram_wr_en = 1'b1;
      end
      jhpm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      jhpm_pkg::ST_SMP_RD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = smp_cell_addr;
      end
      jhpm_pkg::ST_SMP_WR: begin
        in_stall    = 1'b0;
        ram_wr_en   = 1'b1;
        ram_wr_addr = smp_addr_r;
        // count saturates at all ones
        ram_wr_data = (ram_rd_data == CNT_MAX) ? ram_rd_data
                                               : ram_rd_data + COUNT_BITS'(1);
      end
      jhpm_pkg::ST_WALK: begin
        ram_rd_en = 1'b1;
      end
      jhpm_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (state_r == jhpm_pkg::ST_CLEAR) begin
      clr_addr_r <= clr_last ? '0 : clr_addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_col_r <= col_diff[LW-1:0];
      smp_row_r <= row_diff[LW-1:0];
    end
    if (state_r == jhpm_pkg::ST_SMP_RD) begin
      smp_addr_r <= smp_cell_addr;
    end
  end

  // walk pipeline: the read issued in one cycle is summed in the next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= state_r == jhpm_pkg::ST_WALK;
    end
  end

  always_ff @(posedge clk) begin
    prow_r <= row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (in_acc && in_data.op == jhpm_pkg::OP_QUERY) begin
        pass_r  <= 1'b0;
        found_r <= 1'b0;
      end else if (state_r == jhpm_pkg::ST_TAIL && !pass_r) begin
        pass_r <= 1'b1;
      end else if (pv_r && pass_r && !found_r && acc_sum > half_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.op == jhpm_pkg::OP_QUERY) begin
      lo_r    <= in_data.low_bin;
      hi_m1_r <= hi_clip - BW'(1);
      lr_r    <= last_row;
      col_r   <= in_data.low_bin;
      row_r   <= '0;
      base_r  <= '0;
      acc_r   <= '0;
      total_r <= '0;
    end else begin
      if (state_r == jhpm_pkg::ST_WALK) begin
        if (walk_row_end) begin
          col_r  <= lo_r;
          row_r  <= row_r + LW'(1);
          base_r <= base_r + ROW_STRIDE;
        end else begin
          col_r <= col_r + BW'(1);
        end
      end
      if (state_r == jhpm_pkg::ST_TAIL && !pass_r) begin
        // end of the total pass: set up the running-sum pass
        total_r <= acc_sum;
        half_r  <= acc_sum >> 1;
        acc_r   <= '0;
        col_r   <= lo_r;
        row_r   <= '0;
        base_r  <= '0;
      end else begin
        acc_r <= acc_sum;
      end
    end
    // row before the first one whose running sum passes half the total
    if (pv_r && pass_r && !found_r && acc_sum > half_r) begin
      median_r <= jhpm_pkg::ROW_W'({1'b0, prow_r}) - jhpm_pkg::ROW_W'(1);
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.median_row  <= found_r ? median_r
                                        : jhpm_pkg::ROW_W'({1'b0, lr_r});
      out_data_r.piece_total <= (total_r > SUM_W'(jhpm_pkg::TOTAL_MAX))
                                ? jhpm_pkg::TOTAL_MAX
                                : total_r[jhpm_pkg::TOTAL_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/jhpm_checker.sv
// ----------------------------------------------------------------------------
// jhpm_checker
// Port-level checks of the joint histogram median block, bound to its top.
// ----------------------------------------------------------------------------
module jhpm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input jhpm_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input jhpm_pkg::out_item_t out_data
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the memory clearing pass starts right out of reset
  a_reset_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("item taken during clearing pass after reset");

  // a clear item starts a sweep that holds off the next item
  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == jhpm_pkg::OP_CLEAR |=> in_stall)
    else $error("item taken right after a clear item");

  // a query holds the input and never answers in the very next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == jhpm_pkg::OP_QUERY
    |=> in_stall && !$rose(out_valid))
    else $error("query handling overlapped with input or answered too early");

endmodule

bind joint_histogram_piecewise_median_core jhpm_checker u_jhpm_checker (.*);
